/* design/opr_pkg.sv */
package opr_pkg;

  // Fixed field widths
  localparam int PAGE_W = 8;
  localparam int SLOT_W = 3;
  localparam int MISS_W = 7;
  localparam int FIU_W  = 4;

  // Slot count after reset
  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_DECIDE,
    ST_SCAN,
    ST_EVICT,
    ST_OUTPUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // take one reference into the buffer
    logic fetch;    // read the reference being replayed
    logic decide;   // resolve hit or empty slot, or start the future scan
    logic scan;     // step through the future references
    logic evict;    // replace the victim slot
    logic advance;  // result taken, move to the next reference
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic resolved;   // hit or empty slot found, no eviction needed
    logic scan_done;  // victim known
    logic last_ref;   // current reference is the final one
  } sts_t;

endpackage

/* design/opr_ctrl.sv */
module opr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           is_last_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  opr_pkg::sts_t  sts_i,
  output opr_pkg::cmd_t  cmd_o
);

  opr_pkg::state_e state_d, state_q;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= opr_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      opr_pkg::ST_LOAD: begin
        if (in_valid_i && is_last_i) state_d = opr_pkg::ST_FETCH;
      end
      opr_pkg::ST_FETCH: begin
        state_d = opr_pkg::ST_DECIDE;
      end
      opr_pkg::ST_DECIDE: begin
        state_d = sts_i.resolved ? opr_pkg::ST_OUTPUT : opr_pkg::ST_SCAN;
      end
      opr_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_d = opr_pkg::ST_EVICT;
      end
      opr_pkg::ST_EVICT: begin
        state_d = opr_pkg::ST_OUTPUT;
      end
      opr_pkg::ST_OUTPUT: begin
        if (!out_stall_i) begin
          state_d = sts_i.last_ref ? opr_pkg::ST_LOAD : opr_pkg::ST_FETCH;
        end
      end
      default: begin
        state_d = opr_pkg::ST_LOAD;
      end
    endcase
  end

  // Drive commands and handshakes
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      opr_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      opr_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      opr_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
      end
      opr_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      opr_pkg::ST_EVICT: begin
        cmd_o.evict = 1'b1;
      end
      opr_pkg::ST_OUTPUT: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = !out_stall_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* design/opr_dpath.sv */
module opr_dpath #(
  parameter int MAX_FRAMES = 8,
  parameter int MAX_REFS   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [opr_pkg::FIU_W-1:0]     cfg_wdata_i,
  input  logic [opr_pkg::PAGE_W-1:0]    ref_page_i,
  input  logic                          is_last_i,
  input  opr_pkg::cmd_t                 cmd_i,
  output opr_pkg::sts_t                 sts_o,
  output logic [opr_pkg::PAGE_W-1:0]    out_page_o,
  output logic                          hit_o,
  output logic [opr_pkg::SLOT_W-1:0]    slot_o,
  output logic                          evicted_valid_o,
  output logic [opr_pkg::PAGE_W-1:0]    evicted_page_o,
  output logic [opr_pkg::MISS_W-1:0]    miss_total_o,
  output logic                          last_result_o
);

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int AW = $clog2(MAX_REFS);
  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int PW = opr_pkg::PAGE_W;
  localparam int SW = opr_pkg::SLOT_W;
  localparam int MW = opr_pkg::MISS_W;
  localparam int IW = opr_pkg::FIU_W;

  // Lowest set bit of a slot vector
  function automatic logic [FW-1:0] first_set(input logic [MAX_FRAMES-1:0] v);
    logic [FW-1:0] r;
    r = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (v[j]) r = FW'(j);
    end
    return r;
  endfunction

  // Reference buffer
  logic [PW-1:0] mem [MAX_REFS];
  logic [PW-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  // Control registers
  logic [IW-1:0]         fiu_q;
  logic [CW-1:0]         count_q;
  logic [AW-1:0]         i_q;
  logic [CW-1:0]         k_q;
  logic                  data_v_q;
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] found_q;
  logic [MW-1:0]         miss_q;

  // Payload registers
  logic [PW-1:0] pages_q [MAX_FRAMES];
  logic [PW-1:0] p_q;
  logic [FW-1:0] victim_q;

  // Slot match logic
  logic [MAX_FRAMES-1:0] en;
  logic [MAX_FRAMES-1:0] hit_vec;
  logic [MAX_FRAMES-1:0] empty_vec;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] unfound;
  logic                  any_hit;
  logic                  scan_issue;
  logic [FW-1:0]         dec_pos;
  logic [FW-1:0]         ev_pos;
  logic [MW-1:0]         miss_inc;
  logic [CW-1:0]         i_next;
  logic                  store_room;

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      en[j]        = (j == 0) || (int'(fiu_q) > j);
      hit_vec[j]   = en[j] && valid_q[j] && (pages_q[j] == rdata_q);
      empty_vec[j] = en[j] && !valid_q[j];
      match_vec[j] = en[j] && data_v_q && !found_q[j] && (pages_q[j] == rdata_q);
    end
  end

  assign unfound    = en & ~found_q;
  assign any_hit    = |hit_vec;
  assign i_next     = CW'(i_q) + CW'(1);
  assign store_room = count_q < CW'(MAX_REFS);
  assign scan_issue = cmd_i.scan && (k_q < count_q);
  assign dec_pos    = any_hit ? first_set(hit_vec) : first_set(empty_vec);
  assign ev_pos     = (|unfound) ? first_set(unfound) : victim_q;
  assign miss_inc   = (miss_q == '1) ? miss_q : miss_q + MW'(1);
  assign rd_en      = cmd_i.fetch || scan_issue;
  assign rd_addr    = cmd_i.fetch ? i_q : k_q[AW-1:0];

  // Report status
  assign sts_o.resolved  = any_hit || (|empty_vec);
  assign sts_o.scan_done = (~|unfound) || (!data_v_q && (k_q >= count_q));
  assign sts_o.last_ref  = (i_next == count_q);

  // Write and read the reference buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_room) begin
      mem[count_q[AW-1:0]] <= ref_page_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Update control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q    <= opr_pkg::FIU_RESET;
      count_q  <= '0;
      i_q      <= '0;
      k_q      <= '0;
      data_v_q <= 1'b0;
      valid_q  <= '0;
      found_q  <= '0;
      miss_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        fiu_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        if (store_room) count_q <= count_q + CW'(1);
        if (is_last_i) begin
          valid_q <= '0;
          miss_q  <= '0;
          i_q     <= '0;
        end
      end
      if (cmd_i.decide) begin
        if (sts_o.resolved) begin
          if (!any_hit) begin
            valid_q[dec_pos] <= 1'b1;
            miss_q           <= miss_inc;
          end
        end else begin
          k_q      <= i_next;
          found_q  <= '0;
          data_v_q <= 1'b0;
        end
      end
      if (cmd_i.scan) begin
        data_v_q <= scan_issue;
        if (scan_issue) k_q <= k_q + CW'(1);
        found_q <= found_q | match_vec;
      end
      if (cmd_i.evict) begin
        miss_q <= miss_inc;
      end
      if (cmd_i.advance) begin
        if (sts_o.last_ref) begin
          count_q <= '0;
        end else begin
          i_q <= i_q + AW'(1);
        end
      end
    end
  end

  // Update slots and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      p_q <= rdata_q;
      if (sts_o.resolved) begin
        pages_q[dec_pos] <= rdata_q;
        out_page_o       <= rdata_q;
        hit_o            <= any_hit;
        slot_o           <= SW'(dec_pos);
        evicted_valid_o  <= 1'b0;
        evicted_page_o   <= '0;
        miss_total_o     <= any_hit ? miss_q : miss_inc;
        last_result_o    <= sts_o.last_ref;
      end
    end
    // Latest slot to find its next use is the farthest one
    if (cmd_i.scan && (|match_vec)) begin
      victim_q <= first_set(match_vec);
    end
    if (cmd_i.evict) begin
      pages_q[ev_pos] <= p_q;
      out_page_o      <= p_q;
      hit_o           <= 1'b0;
      slot_o          <= SW'(ev_pos);
      evicted_valid_o <= 1'b1;
      evicted_page_o  <= pages_q[ev_pos];
      miss_total_o    <= miss_inc;
      last_result_o   <= sts_o.last_ref;
    end
  end

endmodule

/* design/optimal_page_replacement_unit.sv */
// Loading: one reference item per cycle, stall low while no replay runs.
// Replay: each reference passes fetch, decide and output on a hit or a free
// slot; an eviction adds a buffer scan (one read per cycle) for next uses and
// an evict step before output. Output waits while out_stall_i is high.
// Reset: buffer empty, all slots empty, miss count zero, frames_in_use 8;
// buffer contents themselves are not cleared.
module optimal_page_replacement_unit #(
  parameter int MAX_FRAMES = 8,
  parameter int MAX_REFS   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [opr_pkg::FIU_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [opr_pkg::PAGE_W-1:0]    ref_page_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [opr_pkg::PAGE_W-1:0]    out_page_o,
  output logic                          hit_o,
  output logic [opr_pkg::SLOT_W-1:0]    slot_o,
  output logic                          evicted_valid_o,
  output logic [opr_pkg::PAGE_W-1:0]    evicted_page_o,
  output logic [opr_pkg::MISS_W-1:0]    miss_total_o,
  output logic                          last_result_o
);

  opr_pkg::cmd_t cmd;
  opr_pkg::sts_t sts;

  // Sequence the load and replay
  opr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Buffer, slots and result register
  opr_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_REFS   (MAX_REFS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .ref_page_i      (ref_page_i),
    .is_last_i       (is_last_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_page_o      (out_page_o),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .miss_total_o    (miss_total_o),
    .last_result_o   (last_result_o)
  );

endmodule

/* bench/optimal_page_replacement_unit_test.sv */
`timescale 1ns / 1ps

module optimal_page_replacement_unit_test;

  localparam int MAX_FRAMES     = 8;
  localparam int MAX_REFS       = 64;
  localparam int SETTLE_CYCLES  = MAX_REFS + 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic [opr_pkg::PAGE_W-1:0] page_t;
  typedef logic [opr_pkg::FIU_W-1:0]  fiu_t;

  // One replayed reference as the block should report it
  typedef struct packed {
    logic [opr_pkg::PAGE_W-1:0] out_page;
    logic                       hit;
    logic [opr_pkg::SLOT_W-1:0] slot;
    logic                       evicted_valid;
    logic [opr_pkg::PAGE_W-1:0] evicted_page;
    logic [opr_pkg::MISS_W-1:0] miss_total;
    logic                       last_result;
  } outcome_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [opr_pkg::FIU_W-1:0]  cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [opr_pkg::PAGE_W-1:0] ref_page_i = '0;
  logic                       is_last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [opr_pkg::PAGE_W-1:0] out_page_o;
  logic                       hit_o;
  logic [opr_pkg::SLOT_W-1:0] slot_o;
  logic                       evicted_valid_o;
  logic [opr_pkg::PAGE_W-1:0] evicted_page_o;
  logic [opr_pkg::MISS_W-1:0] miss_total_o;
  logic                       last_result_o;

  // Shadow of the block: buffered string, slot count, outcomes still due
  page_t    loaded_refs[$];
  fiu_t     slot_limit = opr_pkg::FIU_RESET;
  outcome_t pending_outcomes[$];

  int error_count = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  optimal_page_replacement_unit #(
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_REFS  (MAX_REFS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ref_page_i     (ref_page_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_page_o     (out_page_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .miss_total_o   (miss_total_o),
    .last_result_o  (last_result_o)
  );

  always #2 clk_i = ~clk_i;

  // Replay the buffered string against empty slots with Belady's choice
  function automatic void replay_optimal();
    page_t                      slot_page [MAX_FRAMES];
    bit                         slot_full [MAX_FRAMES];
    logic [opr_pkg::MISS_W-1:0] misses;
    outcome_t                   res;
    int nf, n, pos, best, reuse_at, i, j, k;
    bit hit, empty_found;
    nf = (slot_limit == 0) ? 1 :
         ((int'(slot_limit) > MAX_FRAMES) ? MAX_FRAMES : int'(slot_limit));
    n = loaded_refs.size();
    misses = '0;
    for (j = 0; j < MAX_FRAMES; j++) begin
      slot_page[j] = '0;
      slot_full[j] = 1'b0;
    end
    for (i = 0; i < n; i++) begin
      res = '0;
      hit = 1'b0;
      empty_found = 1'b0;
      pos = 0;
      best = 0;
      for (j = 0; j < nf; j++) begin
        if (!hit && slot_full[j] && slot_page[j] == loaded_refs[i]) begin
          hit = 1'b1;
          pos = j;
        end
      end
      if (!hit) begin
        for (j = 0; j < nf; j++) begin
          if (!empty_found && !slot_full[j]) begin
            empty_found = 1'b1;
            pos = j;
          end
        end
        // Victim: first slot never used again, else the farthest next use
        if (!empty_found) begin
          for (j = 0; j < nf; j++) begin
            reuse_at = n;
            for (k = i + 1; k < n; k++) begin
              if (reuse_at == n && loaded_refs[k] == slot_page[j]) reuse_at = k;
            end
            if (j == 0 || reuse_at > best) begin
              best = reuse_at;
              pos = j;
            end
          end
          res.evicted_valid = 1'b1;
          res.evicted_page = slot_page[pos];
        end
        slot_page[pos] = loaded_refs[i];
        slot_full[pos] = 1'b1;
        if (misses < 127) misses++;
      end
      res.out_page = loaded_refs[i];
      res.hit = hit;
      res.slot = pos[opr_pkg::SLOT_W-1:0];
      res.miss_total = misses;
      res.last_result = (i + 1 == n);
      pending_outcomes.push_back(res);
    end
    loaded_refs.delete();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Offer one reference, with an occasional gap, and predict on acceptance
  task automatic send_ref(input page_t page, input logic last);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 20) gap = $urandom_range(2, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ref_page_i <= page;
    is_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (loaded_refs.size() < MAX_REFS) loaded_refs.push_back(page);
    if (last) replay_optimal();
  endtask

  // Stop offering and wait for every outcome still due
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Write the slot count once the block has gone quiet
  task automatic retune(input fiu_t value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slot_limit = value;
  endtask

  task automatic send_string(input page_t pages[$]);
    int k;
    for (k = 0; k < pages.size(); k++) send_ref(pages[k], k == pages.size() - 1);
  endtask

  // Slots after reset: fill, hit on extremes of the page range
  task automatic test_first_fill();
    send_string({8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5});
  endtask

  // Three slots: victims never used again and farthest next use, ties too
  task automatic test_eviction_choice();
    retune(4'd3);
    send_string({8'd1, 8'd2, 8'd3, 8'd4, 8'd1, 8'd2, 8'd5, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5});
  endtask

  // Zero slots acts as one; too many acts as the maximum; one-item string
  task automatic test_slot_limit_extremes();
    retune(4'd0);
    send_string({8'd7, 8'd7, 8'd8});
    retune(4'd15);
    send_string({8'h5A});
  endtask

  // Overfill the buffer so that the tail, the last item too, is dropped
  task automatic test_store_full();
    page_t pool[6];
    int k;
    retune(4'd4);
    foreach (pool[k]) pool[k] = page_t'($urandom_range(255));
    for (k = 0; k < MAX_REFS + 6; k++) send_ref(pool[$urandom_range(5)], k == MAX_REFS + 5);
  endtask

  // Hold off results long while two strings are offered back to back
  task automatic test_backpressure();
    int s, k;
    retune(4'd3);
    hold_asks++;
    for (s = 0; s < 2; s++) begin
      for (k = 0; k < 13; k++) send_ref(page_t'($urandom_range(7) + 'h30), k == 12);
    end
    drain_results();
  endtask

  // Random strings from small page pools across several slot counts
  task automatic test_random_strings();
    page_t pool[12];
    fiu_t limit;
    int sent, phase, strings, len, pool_n, s, k;
    sent = 0;
    phase = 0;
    while (sent < 80) begin
      case (phase % 6)
        0: limit = 4'd1;
        1: limit = 4'd8;
        2: limit = 4'd0;
        3: limit = 4'd15;
        default: limit = fiu_t'($urandom_range(15));
      endcase
      retune(limit);
      steady = (phase == 0);
      strings = $urandom_range(4, 2);
      for (s = 0; s < strings; s++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(MAX_REFS, 30) : $urandom_range(16, 1);
        pool_n = $urandom_range(12, 2);
        foreach (pool[k]) pool[k] = page_t'($urandom_range(255));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) send_ref(page_t'($urandom_range(255)), k == len - 1);
          else send_ref(pool[$urandom_range(pool_n - 1)], k == len - 1);
          sent++;
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // Drive the result stall: random idling, or a counted long hold
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 20);
    end
  end

  // Compare each accepted result with the oldest outcome due
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result for page 0x%0h with no outcome due", out_page_o);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("out_page", 32'(want.out_page), 32'(out_page_o));
        check_field("hit", 32'(want.hit), 32'(hit_o));
        check_field("slot", 32'(want.slot), 32'(slot_o));
        check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid_o));
        check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page_o));
        check_field("miss_total", 32'(want.miss_total), 32'(miss_total_o));
        check_field("last_result", 32'(want.last_result), 32'(last_result_o));
      end
    end
  end

  // End the run when neither side has moved an item for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("optimal_page_replacement_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_fill();
    test_eviction_choice();
    test_slot_limit_extremes();
    test_store_full();
    test_backpressure();
    test_random_strings();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("optimal_page_replacement_unit verification clean");
    end else begin
      $display("optimal_page_replacement_unit verification failed");
    end
    $finish;
  end

endmodule
